FILE: sv/heightfield_ripple_step_core_defines.svh
// ----------------------------------------------------------------------------
// Ripple core assertion macros
// Shared concurrent assertion forms, switched off by defining ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef HEIGHTFIELD_RIPPLE_STEP_CORE_DEFINES_SVH
`define HEIGHTFIELD_RIPPLE_STEP_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define HRS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("ripple core assertion failed");
`define HRS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ripple core assertion failed");
`else
`define HRS_ASSERT(lbl, prop)
`define HRS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: sv/hrs_pkg.sv
// ----------------------------------------------------------------------------
// Ripple core package
// Field widths, commands, register indexes and grid defaults.
// ----------------------------------------------------------------------------
`default_nettype none
package hrs_pkg;
  localparam int GRID_W_DEF   = 33;
  localparam int GRID_H_DEF   = 25;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int END_WAIT     = 6;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;

  typedef enum logic [1:0] {
    CMD_STEP  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_START = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DROP_COUNT    = 3'd0,
    REG_DROP_INTERVAL = 3'd1,
    REG_DROP_HEIGHT   = 3'd2,
    REG_TAIL_WAIT     = 3'd3,
    REG_DROP_VERTEX   = 3'd4
  } reg_idx_t;

  localparam logic [14:0] DROP_COUNT_RST    = 15'd7;
  localparam logic [15:0] DROP_INTERVAL_RST = 16'd8;
  localparam logic [13:0] DROP_HEIGHT_RST   = 14'd1024;
  localparam logic [15:0] TAIL_WAIT_RST     = 16'd0;
  localparam logic [9:0]  DROP_VERTEX_RST   = 10'd412;
endpackage
`default_nettype wire

FILE: sv/hrs_req_if.sv
// ----------------------------------------------------------------------------
// Ripple command channel
// Valid/ready channel carrying one command word.
// ----------------------------------------------------------------------------
`default_nettype none
interface hrs_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [9:0] vertex_index;
  modport source (output valid, output cmd, output vertex_index, input ready);
  modport sink   (input valid, input cmd, input vertex_index, output ready);
endinterface
`default_nettype wire

FILE: sv/hrs_rsp_if.sv
// ----------------------------------------------------------------------------
// Ripple result channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
`default_nettype none
interface hrs_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [13:0] height;
  logic               finished;
  modport source (output valid, output height, output finished, input ready);
  modport sink   (input valid, input height, input finished, output ready);
endinterface
`default_nettype wire

FILE: sv/heightfield_ripple_step_core.sv
// ----------------------------------------------------------------------------
// Height field ripple step core
// Water ripple simulation over a grid of heights and velocities in memories.
// ----------------------------------------------------------------------------
// Each command word returns exactly one result word. Heights live in two
// ping-pong banks of one height memory and velocities in a second memory, both
// with a registered read. A step streams the live bank through the
// read port in linear order into a shift line two rows deep, so every vertex
// sees its four neighbors and itself, and writes the new height into the
// other bank; the banks swap at the end. The single read port of the height
// memory sets the pace of a step, one vertex per cycle. Start clears the
// live height bank and the velocities with a pass over every vertex before
// its result; the same clearing pass runs after reset, during which no
// command word is taken. The other bank needs no clearing since the next
// step overwrites every entry of it. Configuration writes are taken at any
// time but are meant for idle periods.
`default_nettype none
`include "heightfield_ripple_step_core_defines.svh"
module heightfield_ripple_step_core #(
  parameter int GRID_W = hrs_pkg::GRID_W_DEF,
  parameter int GRID_H = hrs_pkg::GRID_H_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [hrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [hrs_pkg::CFG_DATA_W-1:0] cfg_data,
  hrs_req_if.sink                            req,
  hrs_rsp_if.source                          rsp
);
  localparam int N    = GRID_W * GRID_H;
  localparam int IW   = $clog2(N);
  localparam int HW   = $clog2(2 * N);
  localparam int JEND = N + GRID_W;
  localparam int CW   = $clog2(JEND + 1);
  localparam int XW   = 32;
  localparam int COLW = $clog2(GRID_W);
  localparam int ROWW = $clog2(GRID_H);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_READ  = 4'b0100,
    S_SWEEP = 4'b1000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [14:0] drop_count;
  logic [15:0] drop_interval;
  logic [13:0] drop_height;
  logic [15:0] tail_wait;
  logic [9:0]  drop_vertex;

  always_ff @(posedge clk) begin
    if (rst) begin
      drop_count    <= hrs_pkg::DROP_COUNT_RST;
      drop_interval <= hrs_pkg::DROP_INTERVAL_RST;
      drop_height   <= hrs_pkg::DROP_HEIGHT_RST;
      tail_wait     <= hrs_pkg::TAIL_WAIT_RST;
      drop_vertex   <= hrs_pkg::DROP_VERTEX_RST;
    end else if (cfg_we) begin
      case (hrs_pkg::reg_idx_t'(cfg_index))
        hrs_pkg::REG_DROP_COUNT:    drop_count    <= cfg_data[14:0];
        hrs_pkg::REG_DROP_INTERVAL: drop_interval <= cfg_data;
        hrs_pkg::REG_DROP_HEIGHT:   drop_height   <= cfg_data[13:0];
        hrs_pkg::REG_TAIL_WAIT:     tail_wait     <= cfg_data;
        hrs_pkg::REG_DROP_VERTEX:   drop_vertex   <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // Schedule state.
  logic [14:0]        drops_left;
  logic signed [15:0] wait_counter;
  logic               done_flag;
  logic               dropping;
  logic               cur;

  logic [14:0]        dl_next;
  logic signed [15:0] wc_next;
  logic               sc_drop;
  logic               sc_fin;
  logic               drop_in_grid;
  logic signed [15:0] drop_h16;

  assign drop_in_grid = XW'(drop_vertex) < XW'(N);
  assign drop_h16     = {{2{drop_height[13]}}, drop_height};

  always_comb begin
    dl_next = drops_left;
    wc_next = wait_counter;
    sc_drop = 1'b0;
    sc_fin  = 1'b0;
    if (drops_left != 15'd0) begin
      if (wait_counter == 16'sd0) begin
        sc_drop = 1'b1;
        wc_next = drop_interval;
        dl_next = drops_left - 15'd1;
      end else begin
        wc_next = wait_counter - 16'sd1;
      end
      if (dl_next == 15'd0) begin
        if (tail_wait == 16'd0) begin
          sc_fin  = 1'b1;
          wc_next = 16'(hrs_pkg::END_WAIT);
        end else begin
          wc_next = tail_wait;
        end
      end
    end else begin
      wc_next = wait_counter - 16'sd1;
      if (wc_next[15] || wc_next == 16'sd0) begin
        sc_fin  = 1'b1;
        wc_next = 16'(hrs_pkg::END_WAIT);
      end
    end
  end

  // Memories. The height memory holds both banks, bank 1 above bank 0.
  logic signed [15:0] hmem [2*N];
  logic signed [15:0] vmem [N];
  logic signed [15:0] hq, v_q;
  logic [IW-1:0]      h_raddr, v_raddr, h_waddr, v_waddr;
  logic [HW-1:0]      h_ra, h_wa;
  logic               h_we, h_wbank, v_we;
  logic signed [15:0] h_wdata, v_wdata;

  assign h_ra = HW'(h_raddr) + (cur ? HW'(N) : HW'(0));
  assign h_wa = HW'(h_waddr) + (h_wbank ? HW'(N) : HW'(0));

  always_ff @(posedge clk) begin
    if (h_we) begin
      hmem[h_wa] <= h_wdata;
    end
    hq <= hmem[h_ra];
  end

  always_ff @(posedge clk) begin
    if (v_we) begin
      vmem[v_waddr] <= v_wdata;
    end
    v_q <= vmem[v_raddr];
  end

  // Sweep pipeline.
  logic [CW-1:0]      j, jd, jm;
  logic               p0, rd_in, pc;
  logic [IW-1:0]      cidx, clr_cnt;
  logic [COLW-1:0]    ccol;
  logic [ROWW-1:0]    crow;
  logic signed [15:0] win [2*GRID_W];
  logic signed [15:0] dnew, hc;
  logic signed [17:0] nsum, qdiv;
  logic               s1_valid, s1_border;
  logic signed [17:0] s1_dq;
  logic signed [15:0] s1_vel, s1_hc;
  logic [IW-1:0]      s1_idx;
  logic signed [15:0] vnew, hsum, hclamp;
  logic               accept, rd_ok, rd_ok_r, clr_reply;

  assign jm   = j - CW'(GRID_W);
  assign pc   = p0 && (jd >= CW'(GRID_W));
  assign dnew = rd_in ? hq : 16'sd0;
  assign hc   = (dropping && XW'(cidx) == XW'(drop_vertex)) ? drop_h16 : win[GRID_W-1];

  always_comb begin
    nsum = 18'sd0;
    if (ccol != COLW'(0))          nsum = nsum + 18'(win[GRID_W]);
    if (ccol != COLW'(GRID_W - 1)) nsum = nsum + 18'(win[GRID_W-2]);
    if (crow != ROWW'(0))          nsum = nsum + 18'(win[2*GRID_W-1]);
    if (crow != ROWW'(GRID_H - 1)) nsum = nsum + 18'(dnew);
  end
  // Mean truncated toward zero.
  assign qdiv = (nsum + (nsum[17] ? 18'sd3 : 18'sd0)) >>> 2;

  assign vnew = s1_vel + s1_dq[15:0];
  assign hsum = s1_hc + vnew;
  always_comb begin
    hclamp = hsum;
    if (hsum > 16'sd4096)  hclamp = 16'(hrs_pkg::HEIGHT_LIMIT);
    if (hsum < -16'sd4096) hclamp = -16'(hrs_pkg::HEIGHT_LIMIT);
    if (s1_border)         hclamp = 16'sd0;
  end

  assign accept = req.valid && req.ready;
  assign rd_ok  = XW'(req.vertex_index) < XW'(N);
  assign req.ready = (state == S_IDLE) && !rsp.valid;

  // Memory port steering. Reads always come from the live bank.
  always_comb begin
    h_raddr = IW'(req.vertex_index);
    v_raddr = jm[IW-1:0];
    h_waddr = s1_idx;
    h_wdata = hclamp;
    h_we    = 1'b0;
    h_wbank = cur;
    v_waddr = s1_idx;
    v_wdata = vnew;
    v_we    = 1'b0;
    case (state)
      S_CLEAR: begin
        h_waddr = clr_cnt;
        h_wdata = 16'sd0;
        h_we    = 1'b1;
        v_waddr = clr_cnt;
        v_wdata = 16'sd0;
        v_we    = 1'b1;
      end
      S_SWEEP: begin
        h_raddr = j[IW-1:0];
        h_we    = s1_valid;
        h_wbank = !cur;
        v_we    = s1_valid;
      end
      S_IDLE: begin
        // A finishing step keeps its pulse, unclamped, in the live bank.
        h_waddr = IW'(drop_vertex);
        h_wdata = drop_h16;
        if (accept && hrs_pkg::cmd_t'(req.cmd) == hrs_pkg::CMD_STEP && !done_flag
            && sc_fin && sc_drop && drop_in_grid) begin
          h_we = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pc || (state == S_SWEEP && p0)) begin
      win[0] <= dnew;
      for (int k = 1; k < 2 * GRID_W; k++) begin
        win[k] <= win[k-1];
      end
    end
    jd <= j;
    s1_dq     <= qdiv - 18'(hc);
    s1_vel    <= v_q;
    s1_hc     <= hc;
    s1_idx    <= cidx;
    s1_border <= ccol == COLW'(0) || ccol == COLW'(GRID_W - 1)
              || crow == ROWW'(0) || crow == ROWW'(GRID_H - 1);
    rd_ok_r   <= rd_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_cnt      <= '0;
      clr_reply    <= 1'b0;
      drops_left   <= hrs_pkg::DROP_COUNT_RST;
      wait_counter <= 16'sd0;
      done_flag    <= 1'b0;
      dropping     <= 1'b0;
      cur          <= 1'b0;
      j            <= '0;
      p0           <= 1'b0;
      rd_in        <= 1'b0;
      s1_valid     <= 1'b0;
      cidx         <= '0;
      ccol         <= '0;
      crow         <= '0;
      rsp.valid    <= 1'b0;
      rsp.height   <= 14'sd0;
      rsp.finished <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + IW'(1);
          if (XW'(clr_cnt) == XW'(N - 1)) begin
            state   <= S_IDLE;
            clr_cnt <= '0;
            if (clr_reply) begin
              rsp.valid    <= 1'b1;
              rsp.height   <= 14'sd0;
              rsp.finished <= 1'b0;
            end
          end
        end
        S_IDLE: begin
          if (accept) begin
            rsp.height <= 14'sd0;
            case (hrs_pkg::cmd_t'(req.cmd))
              hrs_pkg::CMD_STEP: begin
                if (done_flag) begin
                  rsp.valid    <= 1'b1;
                  rsp.finished <= 1'b1;
                end else begin
                  drops_left   <= dl_next;
                  wait_counter <= wc_next;
                  if (sc_fin) begin
                    done_flag    <= 1'b1;
                    rsp.valid    <= 1'b1;
                    rsp.finished <= 1'b1;
                  end else begin
                    dropping <= sc_drop && drop_in_grid;
                    state    <= S_SWEEP;
                    j        <= '0;
                    cidx     <= '0;
                    ccol     <= '0;
                    crow     <= '0;
                  end
                end
              end
              hrs_pkg::CMD_READ: begin
                state <= S_READ;
              end
              hrs_pkg::CMD_START: begin
                drops_left   <= drop_count;
                wait_counter <= 16'sd0;
                done_flag    <= 1'b0;
                clr_reply    <= 1'b1;
                state        <= S_CLEAR;
              end
              default: begin
                rsp.valid    <= 1'b1;
                rsp.finished <= done_flag;
              end
            endcase
          end
        end
        S_READ: begin
          rsp.valid    <= 1'b1;
          rsp.height   <= rd_ok_r ? hq[13:0] : 14'sd0;
          rsp.finished <= done_flag;
          state        <= S_IDLE;
        end
        S_SWEEP: begin
          if (XW'(j) < XW'(JEND)) begin
            p0    <= 1'b1;
            rd_in <= XW'(j) < XW'(N);
            j     <= j + CW'(1);
          end else begin
            p0 <= 1'b0;
          end
          s1_valid <= pc;
          if (pc) begin
            cidx <= cidx + IW'(1);
            if (ccol == COLW'(GRID_W - 1)) begin
              ccol <= '0;
              crow <= crow + ROWW'(1);
            end else begin
              ccol <= ccol + COLW'(1);
            end
          end
          if (XW'(j) == XW'(JEND) && !p0 && !s1_valid) begin
            cur          <= !cur;
            state        <= S_IDLE;
            rsp.valid    <= 1'b1;
            rsp.height   <= 14'sd0;
            rsp.finished <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `HRS_ASSERT(a_wb_in_sweep, !s1_valid || state == S_SWEEP)
  `HRS_ASSERT(a_no_take_clear, !(state == S_CLEAR) || !req.ready)
  `HRS_ASSERT_NEXT(a_sweep_reply, state == S_SWEEP && XW'(j) == XW'(JEND) && !p0 && !s1_valid,
                   rsp.valid && state == S_IDLE)
  `HRS_ASSERT_NEXT(a_read_reply, state == S_READ, rsp.valid)
endmodule
`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ripple step core testbench
// Drives command words through the valid/ready channel, keeps its own model
// of the height field and drop schedule, and checks every result word.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int W      = 33;
  localparam int H      = 25;
  localparam int NV     = W * H;
  localparam int STALL_LIMIT = 12000;  // covers a long receiver hold plus a step
  localparam int HOLD_CYCLES = 3000;

  typedef struct {
    hrs_pkg::cmd_t cmd;
    logic [9:0]    vidx;
  } cmd_word_t;

  typedef struct {
    logic signed [13:0] height;
    logic               finished;
  } result_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [hrs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [hrs_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  hrs_req_if req_ch ();
  hrs_rsp_if rsp_ch ();

  heightfield_ripple_step_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Words waiting to be sent, and results the model says are on their way.
  cmd_word_t    pending_words[$];
  result_word_t expected_results[$];
  int           mismatches = 0;

  // ---------------------------------------------------------------------------
  // Model of the block: its own copy of the registers and of the grid state.
  // ---------------------------------------------------------------------------
  logic [14:0] m_drop_count    = hrs_pkg::DROP_COUNT_RST;
  logic [15:0] m_drop_interval = hrs_pkg::DROP_INTERVAL_RST;
  logic [13:0] m_drop_height   = hrs_pkg::DROP_HEIGHT_RST;
  logic [15:0] m_tail_wait     = hrs_pkg::TAIL_WAIT_RST;
  logic [9:0]  m_drop_vertex   = hrs_pkg::DROP_VERTEX_RST;

  shortint     heights  [0:NV-1];
  shortint     velocity [0:NV-1];
  shortint     snapshot [0:NV-1];
  int unsigned drops_left;
  shortint     wait_ctr;
  logic        ripple_done;

  // Start clears the field and reloads the pulse schedule.
  function automatic void restart_ripple();
    for (int i = 0; i < NV; i++) begin
      heights[i]  = 0;
      velocity[i] = 0;
    end
    drops_left  = m_drop_count;
    wait_ctr    = 0;
    ripple_done = 1'b0;
  endfunction

  // Advances the pulse schedule by one step. Returns 1 when the schedule has
  // just run out; the caller then skips the wave update, but a pulse dropped on that step stays.
  function automatic bit advance_schedule();
    if (drops_left > 0) begin
      if (wait_ctr == 0) begin
        // A drop vertex beyond the grid skips the write but keeps counting.
        if (m_drop_vertex < NV)
          heights[m_drop_vertex] = shortint'($signed(m_drop_height));
        wait_ctr = shortint'(m_drop_interval);
        drops_left--;
      end else begin
        wait_ctr = wait_ctr - 16'sd1;
      end
      if (drops_left == 0) begin
        if (m_tail_wait == 0) begin
          wait_ctr = shortint'(hrs_pkg::END_WAIT);
          return 1'b1;
        end
        // A tail above 32767 loads as negative and ends on the next step.
        wait_ctr = shortint'(m_tail_wait);
      end
    end else begin
      wait_ctr = wait_ctr - 16'sd1;
      if (wait_ctr <= 0) begin
        wait_ctr = shortint'(hrs_pkg::END_WAIT);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // One wave step over the whole grid, neighbors taken from the snapshot.
  function automatic void wave_update();
    int col, row, sum, h;
    for (int i = 0; i < NV; i++) begin
      col = i % W;
      row = i / W;
      sum = 0;
      if (col > 0)     sum += snapshot[i-1];
      if (col < W - 1) sum += snapshot[i+1];
      if (row > 0)     sum += snapshot[i-W];
      if (row < H - 1) sum += snapshot[i+W];
      // Integer division truncates toward zero, as the mean must.
      velocity[i] = shortint'(int'(velocity[i]) + (sum / 4 - int'(heights[i])));
      h = int'(shortint'(int'(heights[i]) + int'(velocity[i])));
      if (h > hrs_pkg::HEIGHT_LIMIT)  h = hrs_pkg::HEIGHT_LIMIT;
      if (h < -hrs_pkg::HEIGHT_LIMIT) h = -hrs_pkg::HEIGHT_LIMIT;
      if (col == 0 || col == W - 1 || row == 0 || row == H - 1) h = 0;
      heights[i] = shortint'(h);
    end
  endfunction

  // Applies one accepted command word and returns the result it must give.
  function automatic result_word_t ripple_predict(cmd_word_t w);
    result_word_t r;
    shortint hv;
    hv = 0;
    case (w.cmd)
      hrs_pkg::CMD_STEP: begin
        // A step after the end is ignored until the next start.
        if (!ripple_done) begin
          for (int i = 0; i < NV; i++) snapshot[i] = heights[i];
          if (advance_schedule()) ripple_done = 1'b1;
          else wave_update();
        end
      end
      hrs_pkg::CMD_READ: begin
        if (w.vidx < NV) hv = heights[w.vidx];
      end
      hrs_pkg::CMD_START: begin
        restart_ripple();
      end
      default: begin
      end
    endcase
    r.height   = hv[13:0];
    r.finished = ripple_done;
    return r;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length separated by random gaps. A word stays on
  // the channel until it is taken, and the model is run at the taking edge.
  // ---------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready)
        expected_results.push_back(ripple_predict('{hrs_pkg::cmd_t'(req_ch.cmd),
                                                    req_ch.vertex_index}));
      if (req_ch.valid && !req_ch.ready) begin
        // Hold the word until the block takes it.
      end else if (gap_left > 0) begin
        gap_left--;
        req_ch.valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        cmd_word_t w;
        w = pending_words.pop_front();
        req_ch.cmd          <= w.cmd;
        req_ch.vertex_index <= w.vidx;
        req_ch.valid        <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 16);
          // About a third of the bursts run back to back with no gap.
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
        end
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: a 16-bit ready mask, stepped through bit by bit and redrawn
  // periodically, sometimes as all ones. After the 30th result word it holds off for a long stretch so that
  // the block backs up and stops taking commands.
  // ---------------------------------------------------------------------------
  logic [15:0] ready_mask  = 16'hFFFF;
  int          mask_age    = 0;
  int          hold_left   = 0;
  int          words_taken = 0;
  bit          hold_done   = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) words_taken++;
      if (!hold_done && words_taken >= 30) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      mask_age++;
      if (mask_age == 64) begin
        mask_age   = 0;
        ready_mask = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ready_mask[mask_age % 16];
      end
    end
  end

  // Monitor: each taken result word is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected word", rsp_ch.height, 0);
      end else begin
        result_word_t want;
        want = expected_results.pop_front();
        if (rsp_ch.height !== want.height)
          report_mismatch("height", rsp_ch.height, want.height);
        if (rsp_ch.finished !== want.finished)
          report_mismatch("finished", rsp_ch.finished, want.finished);
      end
    end
  end

  // Watchdog: too many cycles without any word moving ends the run.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("FAIL heightfield_ripple_step_core");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic void queue_word(hrs_pkg::cmd_t c, int v);
    pending_words.push_back('{c, 10'(v)});
  endfunction

  // Random word: mostly steps and reads, some unused codes and restarts.
  // Reads mostly land in the grid, some around the drop vertex, some beyond.
  function automatic void queue_random_word();
    int r, v;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 9) == 0)
      v = $urandom_range(NV, 1023);
    else if ($urandom_range(0, 4) == 0)
      v = int'(m_drop_vertex) + $urandom_range(0, 2 * W) - W;
    else
      v = $urandom_range(0, NV - 1);
    if (v < 0) v = 0;
    if (r < 62)      queue_word(hrs_pkg::CMD_STEP, $urandom_range(0, 1023));
    else if (r < 92) queue_word(hrs_pkg::CMD_READ, v);
    else if (r < 96) queue_word(hrs_pkg::CMD_NONE, $urandom_range(0, 1023));
    else             queue_word(hrs_pkg::CMD_START, $urandom_range(0, 1023));
  endfunction

  task automatic wait_idle();
    while (pending_words.size() > 0 || req_ch.valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(hrs_pkg::reg_idx_t idx, logic [15:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      hrs_pkg::REG_DROP_COUNT:    m_drop_count    = value[14:0];
      hrs_pkg::REG_DROP_INTERVAL: m_drop_interval = value;
      hrs_pkg::REG_DROP_HEIGHT:   m_drop_height   = value[13:0];
      hrs_pkg::REG_TAIL_WAIT:     m_tail_wait     = value;
      hrs_pkg::REG_DROP_VERTEX:   m_drop_vertex   = value[9:0];
      default: begin
      end
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // One phase: new schedule settings, a start, then random words.
  task automatic run_phase(int count, int interval, int drop_h, int tail, int vertex,
                           int n_words);
    wait_idle();
    write_reg(hrs_pkg::REG_DROP_COUNT, 16'(count));
    write_reg(hrs_pkg::REG_DROP_INTERVAL, 16'(interval));
    write_reg(hrs_pkg::REG_DROP_HEIGHT, 16'(drop_h));
    write_reg(hrs_pkg::REG_TAIL_WAIT, 16'(tail));
    write_reg(hrs_pkg::REG_DROP_VERTEX, 16'(vertex));
    queue_word(hrs_pkg::CMD_START, 0);
    repeat (n_words) queue_random_word();
  endtask

  initial begin
    req_ch.valid        = 1'b0;
    req_ch.cmd          = hrs_pkg::CMD_NONE;
    req_ch.vertex_index = '0;
    rsp_ch.ready        = 1'b0;
    restart_ripple();
    for (int i = 0; i < NV; i++) snapshot[i] = 0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part on the reset settings: reads at the grid corners and past
    // its end, the unused code, and pulses around the default drop vertex.
    queue_word(hrs_pkg::CMD_READ, 0);
    queue_word(hrs_pkg::CMD_READ, NV - 1);
    queue_word(hrs_pkg::CMD_READ, NV);
    queue_word(hrs_pkg::CMD_READ, 1023);
    queue_word(hrs_pkg::CMD_NONE, 1023);
    queue_word(hrs_pkg::CMD_STEP, 0);
    queue_word(hrs_pkg::CMD_READ, 412);
    queue_word(hrs_pkg::CMD_STEP, 0);
    queue_word(hrs_pkg::CMD_READ, 411);
    queue_word(hrs_pkg::CMD_READ, 413);
    queue_word(hrs_pkg::CMD_READ, 412 - W);
    queue_word(hrs_pkg::CMD_READ, 412 + W);
    queue_word(hrs_pkg::CMD_READ, 412);
    wait_idle();
    // No drops and no tail: the first step ends the schedule at once, the
    // next one is ignored.
    write_reg(hrs_pkg::REG_DROP_COUNT, 16'd0);
    queue_word(hrs_pkg::CMD_START, 0);
    queue_word(hrs_pkg::CMD_STEP, 0);
    queue_word(hrs_pkg::CMD_STEP, 0);
    queue_word(hrs_pkg::CMD_NONE, 0);
    queue_word(hrs_pkg::CMD_READ, 412);

    // Settings that sweep each register across its extremes. The pulse on a
    // finishing step is left unclamped, which the short schedules exercise.
    run_phase(7, 8, 1024, 0, 412, 70);          // reset schedule, runs to its end
    run_phase(0, 0, -4096, 0, 0, 20);           // nothing dropped, border vertex
    run_phase(32767, 65535, 4096, 65535, 824, 35);
    run_phase(3, 0, 4096, 5, 412, 45);          // a pulse every step, short tail
    run_phase(2, 3, -4096, 1, 1000, 30);        // drop vertex beyond the grid
    run_phase(2, 1, 4000, 65535, 34, 25);       // tail loads as negative
    run_phase(5, 2, $urandom_range(0, 8192) - 4096, 20, $urandom_range(0, NV - 1), 60);
    run_phase(4, 32768, -1, 3, 446, 25);        // interval loads as negative

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS heightfield_ripple_step_core");
    end else begin
      $display("FAIL heightfield_ripple_step_core");
    end
    $finish;
  end

endmodule
